// ===== rtl/skvt_pkg.sv =====
// Shared constants and item types for the sorted key/value table.
`timescale 1ns / 1ps
package skvt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W     = KEY_WIDTH + VALUE_WIDTH;

  typedef enum logic [2:0] {
    OP_INSERT     = 3'd0,
    OP_REMOVE_KEY = 3'd1,
    OP_REMOVE_AT  = 3'd2,
    OP_LOOKUP     = 3'd3,
    OP_COUNT      = 3'd4,
    OP_READ       = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]             kind;
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
    logic [ADDR_W-1:0]      position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             status;
    logic                   found;
    logic [CNT_W-1:0]       slot;
    logic [VALUE_WIDTH-1:0] data_out;
    logic [CNT_W-1:0]       match_count;
    logic [CNT_W-1:0]       entry_count;
  } out_item_t;

endpackage

// ===== rtl/skvt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module skvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sorted_key_value_table_top.sv =====
// Sorted key/value table: binary search and entry shifting over one RAM.
//
//   channel   direction  handshake                 payload
//   in        input      in_valid_i / in_ready_o   in_item_i  (in_item_t)
//   out       output     out_valid_o / out_ready_i out_item_o (out_item_t)
//   cfg       input      cfg_we_i                  cfg_wdata_i (signed_keys)
//
// One item at a time; n is the entry count. Search is binary, at most 7 steps.
// Insert then shifts the entries from the slot to n-1 up by one, removes shift
// the entries after the slot down by one, count reads all n entries and compares
// each key, reads at an index fetch one entry; every item then waits
// in the result register. Every step goes through the single read port of the entry RAM.
// Reset clears the count and the key order; RAM contents stay unknown and are never read.
// A stalled result holds the block; in_ready_o is low until it is taken.
`timescale 1ns / 1ps
module sorted_key_value_table_top
  import skvt_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SEARCH = 7'b0000010,
    S_FETCH  = 7'b0000100,
    S_SHUP   = 7'b0001000,
    S_SHDN   = 7'b0010000,
    S_COUNT  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_e;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       used_q, used_d;
  logic                   signed_q;
  logic                   pend_q, pend_d;

  logic [2:0]             kind_q, kind_d;
  logic [KEY_WIDTH-1:0]   key_q, key_d;
  logic [VALUE_WIDTH-1:0] val_q, val_d;
  logic [CNT_W-1:0]       lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [CNT_W-1:0]       idx_q, idx_d, rp_q, rp_d;
  logic [ADDR_W-1:0]      wa_q, wa_d;
  status_e                status_q, status_d;
  logic                   found_q, found_d;
  logic [CNT_W-1:0]       slot_q, slot_d;
  logic [VALUE_WIDTH-1:0] data_q, data_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]     ram_wdata, ram_rdata;

  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [KEY_WIDTH-1:0]   sign_flip;
  logic                   key_gt, key_eq;
  logic [CNT_W-1:0]       lo_n, hi_n, mid_n;
  logic [CNT_W:0]         mid_sum;
  logic                   accept;

  skvt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_key    = ram_rdata[ENTRY_W-1 -: KEY_WIDTH];
  assign rd_val    = ram_rdata[VALUE_WIDTH-1:0];
  assign sign_flip = KEY_WIDTH'(signed_q) << (KEY_WIDTH - 1);
  assign key_eq    = (key_q == rd_key);
  assign key_gt    = ((key_q ^ sign_flip) > (rd_key ^ sign_flip));
  assign lo_n      = key_gt ? CNT_W'(mid_q + 1'b1) : lo_q;
  assign hi_n      = key_gt ? hi_q : mid_q;
  assign mid_sum   = {1'b0, lo_n} + {1'b0, hi_n};
  assign mid_n     = mid_sum[CNT_W:1];

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = (state_q == S_DONE);

  always_comb begin
    out_item_o             = '0;
    out_item_o.status      = status_q;
    out_item_o.found       = found_q;
    out_item_o.slot        = slot_q;
    out_item_o.data_out    = data_q;
    out_item_o.match_count = cnt_q;
    out_item_o.entry_count = used_q;
  end

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    pend_d    = pend_q;
    kind_d    = kind_q;
    key_d     = key_q;
    val_d     = val_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    idx_d     = idx_q;
    rp_d      = rp_q;
    wa_d      = wa_q;
    status_d  = status_q;
    found_d   = found_q;
    slot_d    = slot_q;
    data_d    = data_q;
    cnt_d     = cnt_q;
    ram_we    = 1'b0;
    ram_waddr = wa_q;
    ram_wdata = ram_rdata;
    ram_raddr = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_item_i.kind == OP_REMOVE_AT || in_item_i.kind == OP_READ) begin
          ram_raddr = in_item_i.position;
        end else begin
          ram_raddr = ADDR_W'(used_q >> 1);
        end
        if (accept) begin
          kind_d   = in_item_i.kind;
          key_d    = in_item_i.key;
          val_d    = in_item_i.value;
          status_d = ST_OK;
          found_d  = 1'b0;
          slot_d   = '0;
          data_d   = '0;
          cnt_d    = '0;
          pend_d   = 1'b0;
          lo_d     = '0;
          hi_d     = used_q;
          mid_d    = used_q >> 1;
          case (in_item_i.kind)
            OP_INSERT: begin
              if (used_q == CNT_W'(TABLE_DEPTH)) begin
                status_d = ST_FULL;
                state_d  = S_DONE;
              end else if (used_q == '0) begin
                idx_d   = '0;
                rp_d    = '0;
                state_d = S_SHUP;
              end else begin
                state_d = S_SEARCH;
              end
            end
            OP_REMOVE_KEY, OP_LOOKUP: begin
              if (used_q == '0) begin
                status_d = ST_NOT_FOUND;
                state_d  = S_DONE;
              end else begin
                state_d = S_SEARCH;
              end
            end
            OP_REMOVE_AT, OP_READ: begin
              if (CNT_W'(in_item_i.position) >= used_q) begin
                status_d = ST_BAD_INDEX;
                state_d  = S_DONE;
              end else begin
                slot_d  = CNT_W'(in_item_i.position);
                rp_d    = CNT_W'(in_item_i.position) + 1'b1;
                state_d = S_FETCH;
              end
            end
            OP_COUNT: begin
              rp_d    = '0;
              state_d = S_COUNT;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_SEARCH: begin
        ram_raddr = ADDR_W'(mid_n);
        lo_d      = lo_n;
        hi_d      = hi_n;
        mid_d     = mid_n;
        if (key_eq || (lo_n >= hi_n)) begin
          idx_d  = key_eq ? mid_q : mid_n;
          slot_d = key_eq ? mid_q : mid_n;
          if (kind_q == OP_INSERT) begin
            found_d = key_eq;
            rp_d    = used_q;
            state_d = S_SHUP;
          end else if (key_eq) begin
            found_d = 1'b1;
            data_d  = rd_val;
            rp_d    = CNT_W'(mid_q + 1'b1);
            state_d = (kind_q == OP_REMOVE_KEY) ? S_SHDN : S_DONE;
          end else begin
            status_d = ST_NOT_FOUND;
            state_d  = S_DONE;
          end
        end
      end

      S_FETCH: begin
        data_d  = rd_val;
        state_d = (kind_q == OP_REMOVE_AT) ? S_SHDN : S_DONE;
      end

      S_SHUP: begin
        ram_we = pend_q;
        if (rp_q > idx_q) begin
          ram_raddr = ADDR_W'(rp_q - 1'b1);
          pend_d    = 1'b1;
          wa_d      = ADDR_W'(rp_q);
          rp_d      = rp_q - 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            ram_we    = 1'b1;
            ram_waddr = ADDR_W'(idx_q);
            ram_wdata = {key_q, val_q};
            used_d    = used_q + 1'b1;
            state_d   = S_DONE;
          end
        end
      end

      S_SHDN: begin
        ram_we = pend_q;
        if (rp_q < used_q) begin
          ram_raddr = ADDR_W'(rp_q);
          pend_d    = 1'b1;
          wa_d      = ADDR_W'(rp_q - 1'b1);
          rp_d      = rp_q + 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            used_d  = used_q - 1'b1;
            state_d = S_DONE;
          end
        end
      end

      S_COUNT: begin
        if (pend_q && key_eq) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (rp_q < used_q) begin
          ram_raddr = ADDR_W'(rp_q);
          pend_d    = 1'b1;
          rp_d      = rp_q + 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            state_d = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      used_q   <= '0;
      signed_q <= 1'b0;
      pend_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      pend_q  <= pend_d;
      if (cfg_we_i) begin
        signed_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    key_q    <= key_d;
    val_q    <= val_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    idx_q    <= idx_d;
    rp_q     <= rp_d;
    wa_q     <= wa_d;
    status_q <= status_d;
    found_q  <= found_d;
    slot_q   <= slot_d;
    data_q   <= data_d;
    cnt_q    <= cnt_d;
  end

endmodule
